/* rtl/pie_pkg.sv */
// Shared types, opcodes and control register codes for the privileged instruction emulator.
`default_nettype none

package pie_pkg;

    // Configuration port geometry
    localparam int unsigned ApbAddrWidth = 3;
    localparam int unsigned ApbDataWidth = 32;

    // Register indexes on the configuration port
    localparam logic [0:0] REG_CPU_MODEL        = 1'b0;
    localparam logic [0:0] REG_EMULATE_OBSOLETE = 1'b1;

    // Reset values of the configuration registers
    localparam logic [5:0] CPU_MODEL_RESET        = 6'd30;
    localparam logic       EMULATE_OBSOLETE_RESET = 1'b1;

    // Opcodes and masks
    localparam logic [15:0] OP_MOVE_SR_MASK = 16'hffc0;
    localparam logic [15:0] OP_MOVE_FROM_SR = 16'h40c0;
    localparam logic [15:0] OP_ANDI_SR      = 16'h027c;
    localparam logic [15:0] OP_EORI_SR      = 16'h0a7c;
    localparam logic [15:0] OP_ORI_SR       = 16'h007c;
    localparam logic [15:0] OP_RESET        = 16'h4e70;
    localparam logic [15:0] OP_STOP         = 16'h4e72;
    localparam logic [15:0] OP_MOVEC_READ   = 16'h4e7a;
    localparam logic [15:0] OP_MOVEC_WRITE  = 16'h4e7b;

    // Status register masks
    localparam logic [15:0] SR_MOVE_MASK = 16'h20ff;
    localparam logic [15:0] SR_ANDI_KEEP = 16'hffe0;
    localparam logic [15:0] SR_CCR_MASK  = 16'h001f;

    // MOVE from SR effective address modes
    localparam logic [2:0] EA_DREG     = 3'd0;
    localparam logic [2:0] EA_AREG     = 3'd1;
    localparam logic [2:0] EA_AIND     = 3'd2;
    localparam logic [2:0] EA_POSTINC  = 3'd3;
    localparam logic [2:0] EA_PREDEC   = 3'd4;
    localparam logic [2:0] EA_DISP     = 3'd5;
    localparam logic [2:0] EA_INDEX    = 3'd6;
    localparam logic [2:0] EA_SPECIAL  = 3'd7;

    // CPU generations used as thresholds
    localparam logic [5:0] CPU_GEN_10 = 6'd10;
    localparam logic [5:0] CPU_GEN_20 = 6'd20;
    localparam logic [5:0] CPU_GEN_30 = 6'd30;
    localparam logic [5:0] CPU_GEN_40 = 6'd40;

    // MOVEC control register codes
    localparam logic [11:0] CTL_SFC   = 12'h000;
    localparam logic [11:0] CTL_DFC   = 12'h001;
    localparam logic [11:0] CTL_CACR  = 12'h002;
    localparam logic [11:0] CTL_TC    = 12'h003;
    localparam logic [11:0] CTL_DTT1  = 12'h007;
    localparam logic [11:0] CTL_USP   = 12'h800;
    localparam logic [11:0] CTL_VBR   = 12'h801;
    localparam logic [11:0] CTL_CAAR  = 12'h802;
    localparam logic [11:0] CTL_MSP   = 12'h803;
    localparam logic [11:0] CTL_ISP   = 12'h804;
    localparam logic [11:0] CTL_MMUSR = 12'h805;
    localparam logic [11:0] CTL_SRP   = 12'h807;

    // STOP: an immediate that keeps S set (trace bits clear) with an IPL above this kills
    localparam logic [2:0] STOP_IPL_LIMIT = 3'd5;

    // What a MOVEC read returns
    typedef enum logic [1:0] {
        MOVEC_NONE = 2'd0,
        MOVEC_ZERO = 2'd1,
        MOVEC_USP  = 2'd2
    } pie_movec_kind_t;

    // Configuration as seen by the decoder
    typedef struct packed {
        logic [5:0] cpu_model;
        logic       emulate_obsolete;
    } pie_cfg_t;

    // One trapped instruction word
    typedef struct packed {
        logic [15:0] opcode;
        logic [15:0] ext_word;
        logic [15:0] status_reg;
        logic [31:0] reg_value;
        logic [31:0] usp_value;
        logic        pretend_super;
    } pie_item_t;

    // One verdict word
    typedef struct packed {
        logic        resume;
        logic [1:0]  pc_advance;
        logic [15:0] new_status;
        logic        reg_write_en;
        logic        reg_write_addr;
        logic [2:0]  reg_write_index;
        logic [31:0] reg_write_value;
        logic        pretend_super_next;
    } pie_result_t;

endpackage

`default_nettype wire

/* rtl/pie_apb_regs.sv */
// Configuration registers behind the APB-style port.
`default_nettype none

module pie_apb_regs (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [pie_pkg::ApbAddrWidth-1:0]     paddr,
    input  wire logic [pie_pkg::ApbDataWidth-1:0]     pwdata,
    output logic      [pie_pkg::ApbDataWidth-1:0]     prdata,
    output logic                                      pready,
    output pie_pkg::pie_cfg_t                         cfg
);
    import pie_pkg::*;

    logic [5:0]  cpu_model_reg;
    logic        emulate_obsolete_reg;
    logic        wr_en;
    logic [0:0]  reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Write the selected register on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_model_reg        <= CPU_MODEL_RESET;
            emulate_obsolete_reg <= EMULATE_OBSOLETE_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_CPU_MODEL:        cpu_model_reg        <= pwdata[5:0];
                REG_EMULATE_OBSOLETE: emulate_obsolete_reg <= pwdata[0];
                default:              cpu_model_reg        <= cpu_model_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_sel)
            REG_CPU_MODEL:        prdata = {{(ApbDataWidth-6){1'b0}}, cpu_model_reg};
            REG_EMULATE_OBSOLETE: prdata = {{(ApbDataWidth-1){1'b0}}, emulate_obsolete_reg};
            default:              prdata = '0;
        endcase
    end

    assign cfg.cpu_model        = cpu_model_reg;
    assign cfg.emulate_obsolete = emulate_obsolete_reg;

endmodule

`default_nettype wire

/* rtl/pie_decode.sv */
// Decode of one trapped instruction into its verdict.
`default_nettype none

module pie_decode (
    input  pie_pkg::pie_cfg_t    cfg,
    input  pie_pkg::pie_item_t   item,
    output pie_pkg::pie_result_t result
);
    import pie_pkg::*;

    // Classify a MOVEC read by CPU generation and control code
    function automatic pie_movec_kind_t movec_kind(input logic [5:0] m,
                                                   input logic [11:0] ctl);
        pie_movec_kind_t k;
        k = MOVEC_NONE;
        if (m >= CPU_GEN_40)
        begin
            if ((ctl >= CTL_TC && ctl <= CTL_DTT1) ||
                (ctl >= CTL_MMUSR && ctl <= CTL_SRP))
                k = MOVEC_ZERO;
        end
        if (m >= CPU_GEN_20)
        begin
            if (ctl == CTL_CACR)
                k = MOVEC_ZERO;
            else if (ctl == CTL_CAAR)
                k = (m == CPU_GEN_20 || m == CPU_GEN_30) ? MOVEC_ZERO : MOVEC_NONE;
            else if (ctl == CTL_MSP || ctl == CTL_ISP)
                k = MOVEC_USP;
        end
        if (m >= CPU_GEN_10)
        begin
            if (ctl == CTL_SFC || ctl == CTL_DFC || ctl == CTL_VBR)
                k = MOVEC_ZERO;
            else if (ctl == CTL_USP)
                k = MOVEC_USP;
        end
        return k;
    endfunction

    logic [2:0]      ea_mode;
    logic [2:0]      ea_reg;
    logic            is_move_sr;
    logic            stop_kill;
    pie_movec_kind_t mkind;

    assign ea_mode    = item.opcode[5:3];
    assign ea_reg     = item.opcode[2:0];
    assign is_move_sr = cfg.emulate_obsolete &&
                        ((item.opcode & OP_MOVE_SR_MASK) == OP_MOVE_FROM_SR);
    assign stop_kill  = (item.ext_word[15:13] == 3'b001) &&
                        (item.ext_word[10:8] > STOP_IPL_LIMIT);
    assign mkind      = movec_kind(cfg.cpu_model, item.ext_word[11:0]);

    // Pick the verdict; default is a privilege violation
    always_comb
    begin
        result                    = '0;
        result.new_status         = item.status_reg;
        result.pretend_super_next = item.pretend_super;

        if (is_move_sr)
        begin
            case (ea_mode)
                EA_DREG:
                begin
                    result.resume          = 1'b1;
                    result.pc_advance      = 2'd1;
                    result.reg_write_en    = 1'b1;
                    result.reg_write_index = ea_reg;
                    result.reg_write_value = {item.reg_value[31:16],
                                              item.status_reg & SR_MOVE_MASK};
                end
                EA_AIND:
                begin
                    result.resume     = 1'b1;
                    result.pc_advance = 2'd1;
                end
                EA_POSTINC:
                begin
                    result.resume          = 1'b1;
                    result.pc_advance      = 2'd1;
                    result.reg_write_en    = 1'b1;
                    result.reg_write_addr  = 1'b1;
                    result.reg_write_index = ea_reg;
                    result.reg_write_value = item.reg_value + 32'd2;
                end
                EA_PREDEC:
                begin
                    result.resume          = 1'b1;
                    result.pc_advance      = 2'd1;
                    result.reg_write_en    = 1'b1;
                    result.reg_write_addr  = 1'b1;
                    result.reg_write_index = ea_reg;
                    result.reg_write_value = item.reg_value - 32'd2;
                end
                EA_DISP:
                begin
                    result.resume     = 1'b1;
                    result.pc_advance = 2'd2;
                end
                EA_SPECIAL:
                begin
                    result.resume     = 1'b1;
                    result.pc_advance = (ea_reg == 3'd0) ? 2'd2 : 2'd3;
                end
                default:
                begin
                    result.resume = 1'b0;
                end
            endcase
        end
        else if (item.pretend_super)
        begin
            case (item.opcode)
                OP_ANDI_SR:
                begin
                    result.resume     = 1'b1;
                    result.pc_advance = 2'd2;
                    result.new_status = item.status_reg & (item.ext_word | SR_ANDI_KEEP);
                    result.pretend_super_next = item.ext_word[13] ? item.pretend_super
                                                                  : 1'b0;
                end
                OP_EORI_SR:
                begin
                    result.resume     = 1'b1;
                    result.pc_advance = 2'd2;
                    result.new_status = item.status_reg ^ (item.ext_word & SR_CCR_MASK);
                    result.pretend_super_next = item.ext_word[13] ? 1'b0
                                                                  : item.pretend_super;
                end
                OP_ORI_SR:
                begin
                    result.resume     = 1'b1;
                    result.pc_advance = 2'd2;
                    result.new_status = item.status_reg | (item.ext_word & SR_CCR_MASK);
                end
                OP_RESET:
                begin
                    result.resume     = 1'b1;
                    result.pc_advance = 2'd1;
                end
                OP_STOP:
                begin
                    result.resume     = !stop_kill;
                    result.pc_advance = stop_kill ? 2'd0 : 2'd2;
                end
                OP_MOVEC_READ:
                begin
                    if (cfg.cpu_model != 6'd0 && mkind != MOVEC_NONE)
                    begin
                        result.resume          = 1'b1;
                        result.pc_advance      = 2'd2;
                        result.reg_write_en    = 1'b1;
                        result.reg_write_addr  = item.ext_word[15];
                        result.reg_write_index = item.ext_word[14:12];
                        result.reg_write_value = (mkind == MOVEC_USP) ? item.usp_value
                                                                      : 32'd0;
                    end
                end
                OP_MOVEC_WRITE:
                begin
                    if (cfg.cpu_model != 6'd0)
                    begin
                        result.resume     = 1'b1;
                        result.pc_advance = 2'd2;
                    end
                end
                default:
                begin
                    result.resume = 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/privileged_instruction_emulator_unit.sv */
// Top level: input register, instruction decode, result register and config port.
// A word goes from the input register through the decode into the result register.
// Throughput: one word per cycle while out_stall is low.
// A stall on the output holds the result register and backs up into the input register.
// Reset clears both valid flags and sets cpu_model to 30 and emulate_obsolete to 1.
`default_nettype none

module privileged_instruction_emulator_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [pie_pkg::ApbAddrWidth-1:0]     paddr,
    input  wire logic [pie_pkg::ApbDataWidth-1:0]     pwdata,
    output logic      [pie_pkg::ApbDataWidth-1:0]     prdata,
    output logic                                      pready,
    // Input channel
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [15:0]                          opcode,
    input  wire logic [15:0]                          ext_word,
    input  wire logic [15:0]                          status_reg,
    input  wire logic [31:0]                          reg_value,
    input  wire logic [31:0]                          usp_value,
    input  wire logic                                 pretend_super,
    // Output channel
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      resume,
    output logic      [1:0]                           pc_advance,
    output logic      [15:0]                          new_status,
    output logic                                      reg_write_en,
    output logic                                      reg_write_addr,
    output logic      [2:0]                           reg_write_index,
    output logic      [31:0]                          reg_write_value,
    output logic                                      pretend_super_next
);
    import pie_pkg::*;

    pie_cfg_t    cfg;
    pie_item_t   item_reg;
    pie_item_t   item_next;
    logic        item_valid_reg;
    logic        item_valid_next;
    pie_result_t dec_result;
    pie_result_t result_reg;
    logic        result_valid_reg;
    logic        result_valid_next;
    logic        result_load;
    logic        item_load;

    pie_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pie_decode u_decode (
        .cfg    (cfg),
        .item   (item_reg),
        .result (dec_result)
    );

    // Handshake: advance the result stage when empty or taken
    assign result_load = !result_valid_reg || !out_stall;
    assign in_stall    = item_valid_reg && !result_load;
    assign item_load   = in_valid && !in_stall;

    assign item_next.opcode        = opcode;
    assign item_next.ext_word      = ext_word;
    assign item_next.status_reg    = status_reg;
    assign item_next.reg_value     = reg_value;
    assign item_next.usp_value     = usp_value;
    assign item_next.pretend_super = pretend_super;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (!in_stall)
            item_valid_next = in_valid;
        result_valid_next = result_valid_reg;
        if (result_load)
            result_valid_next = item_valid_reg;
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item_load)
            item_reg <= item_next;
        if (result_load && item_valid_reg)
            result_reg <= dec_result;
    end

    assign out_valid          = result_valid_reg;
    assign resume             = result_reg.resume;
    assign pc_advance         = result_reg.pc_advance;
    assign new_status         = result_reg.new_status;
    assign reg_write_en       = result_reg.reg_write_en;
    assign reg_write_addr     = result_reg.reg_write_addr;
    assign reg_write_index    = result_reg.reg_write_index;
    assign reg_write_value    = result_reg.reg_write_value;
    assign pretend_super_next = result_reg.pretend_super_next;

    // A stall at the input only arises with a word waiting in the input register
    a_stall_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> item_valid_reg)
        else $error("input stalled with empty input register");

    // A word that moves forward reaches the result register
    a_word_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && result_load) |=> result_valid_reg)
        else $error("word lost between input and result registers");

    // A fault never writes a register nor advances the PC
    a_fault_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !resume) |-> (!reg_write_en && pc_advance == 2'd0))
        else $error("fault verdict with side effects");

    // Register-write fields are zero when no write is made
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !reg_write_en) |->
            (!reg_write_addr && reg_write_index == 3'd0 && reg_write_value == 32'd0))
        else $error("register-write fields set without a write");

endmodule

`default_nettype wire

/* tb/privileged_instruction_emulator_unit_test.sv */
// Self-checking testbench for the privileged instruction emulator: directed table, then random phases.
`timescale 1ns / 100ps

module privileged_instruction_emulator_unit_test;

    import pie_pkg::*;

    localparam int PHASE_COUNT     = 10;
    localparam int WORDS_PER_PHASE = 125;
    localparam int CYCLE_LIMIT     = 1_000_000;

    // One row of the directed table: mode to run in, trapped word, and an optional fixed verdict
    typedef struct packed {
        logic [5:0]  cpu;
        logic        emu;
        pie_item_t   word;
        logic        typed;
        pie_result_t verdict;
    } trap_row_t;

    // Columns: cpu, emu, {opcode, ext, sr, reg, usp, ps}, typed,
    //          {resume, advance, sr, wen, addr, index, value, ps_next}
    localparam trap_row_t TRAP_TABLE [25] = '{
        // MOVE from SR in every addressing mode, reset configuration
        '{6'd30, 1'b1, '{{OP_MOVE_FROM_SR[15:6], EA_DREG, 3'd0}, 16'h0000, 16'hffff,
            32'hffffffff, 32'h00000000, 1'b0}, 1'b1,
            '{1'b1, 2'd1, 16'hffff, 1'b1, 1'b0, 3'd0, 32'hffff20ff, 1'b0}},
        '{6'd30, 1'b1, '{{OP_MOVE_FROM_SR[15:6], EA_AREG, 3'd3}, 16'h0000, 16'h2715,
            32'h89abcdef, 32'h00000000, 1'b0}, 1'b1,
            '{1'b0, 2'd0, 16'h2715, 1'b0, 1'b0, 3'd0, 32'h00000000, 1'b0}},
        '{6'd30, 1'b1, '{{OP_MOVE_FROM_SR[15:6], EA_AIND, 3'd5}, 16'h1234, 16'ha5a5,
            32'h12345678, 32'h00000000, 1'b1}, 1'b0, '0},
        '{6'd30, 1'b1, '{{OP_MOVE_FROM_SR[15:6], EA_POSTINC, 3'd7}, 16'h0000, 16'h0700,
            32'hffffffff, 32'h00000000, 1'b0}, 1'b0, '0},
        '{6'd30, 1'b1, '{{OP_MOVE_FROM_SR[15:6], EA_PREDEC, 3'd0}, 16'h0000, 16'h2004,
            32'h00000000, 32'h00000000, 1'b0}, 1'b0, '0},
        '{6'd30, 1'b1, '{{OP_MOVE_FROM_SR[15:6], EA_DISP, 3'd2}, 16'h0010, 16'h0011,
            32'h00001000, 32'h00000000, 1'b0}, 1'b0, '0},
        '{6'd30, 1'b1, '{{OP_MOVE_FROM_SR[15:6], EA_INDEX, 3'd1}, 16'h0000, 16'h1234,
            32'h00000000, 32'h00000000, 1'b1}, 1'b1,
            '{1'b0, 2'd0, 16'h1234, 1'b0, 1'b0, 3'd0, 32'h00000000, 1'b1}},
        '{6'd30, 1'b1, '{{OP_MOVE_FROM_SR[15:6], EA_SPECIAL, 3'd0}, 16'h0000, 16'h0000,
            32'h00000000, 32'h00000000, 1'b0}, 1'b0, '0},
        '{6'd30, 1'b1, '{{OP_MOVE_FROM_SR[15:6], EA_SPECIAL, 3'd7}, 16'h0000, 16'h0000,
            32'h00000000, 32'h00000000, 1'b0}, 1'b0, '0},
        // Unknown opcode with every field at its top value
        '{6'd30, 1'b1, '{16'hffff, 16'hffff, 16'hffff, 32'hffffffff, 32'hffffffff, 1'b1},
            1'b1, '{1'b0, 2'd0, 16'hffff, 1'b0, 1'b0, 3'd0, 32'h00000000, 1'b1}},
        // Immediate operations on SR, with and without the S bit in the immediate
        '{6'd30, 1'b1, '{OP_ANDI_SR, 16'hffff, 16'hffff, 32'h00000000, 32'h00000000, 1'b1},
            1'b0, '0},
        '{6'd30, 1'b1, '{OP_ANDI_SR, 16'h0000, 16'hffff, 32'h00000000, 32'h00000000, 1'b1},
            1'b0, '0},
        '{6'd30, 1'b1, '{OP_EORI_SR, 16'h2000, 16'h001f, 32'h00000000, 32'h00000000, 1'b1},
            1'b0, '0},
        '{6'd30, 1'b1, '{OP_ORI_SR, 16'hffff, 16'h0000, 32'h00000000, 32'h00000000, 1'b1},
            1'b0, '0},
        // RESET pretending and not pretending supervisor
        '{6'd30, 1'b1, '{OP_RESET, 16'h0000, 16'h2700, 32'h00000000, 32'h00000000, 1'b1},
            1'b0, '0},
        '{6'd30, 1'b1, '{OP_RESET, 16'h0000, 16'h2000, 32'h00000000, 32'h00000000, 1'b0},
            1'b1, '{1'b0, 2'd0, 16'h2000, 1'b0, 1'b0, 3'd0, 32'h00000000, 1'b0}},
        // STOP that raises the IPL to 7, and one that stays at 5
        '{6'd30, 1'b1, '{OP_STOP, 16'h2700, 16'h2000, 32'h00000000, 32'h00000000, 1'b1},
            1'b1, '{1'b0, 2'd0, 16'h2000, 1'b0, 1'b0, 3'd0, 32'h00000000, 1'b1}},
        '{6'd30, 1'b1, '{OP_STOP, 16'h2500, 16'h2000, 32'h00000000, 32'h00000000, 1'b1},
            1'b0, '0},
        // MOVEC reads and writes
        '{6'd30, 1'b1, '{OP_MOVEC_READ, {1'b1, 3'd7, CTL_USP}, 16'h2000, 32'h00000000,
            32'hdeadbeef, 1'b1}, 1'b0, '0},
        '{6'd30, 1'b1, '{OP_MOVEC_READ, 16'hffff, 16'h0000, 32'h00000000, 32'h00000000,
            1'b1}, 1'b1, '{1'b0, 2'd0, 16'h0000, 1'b0, 1'b0, 3'd0, 32'h00000000, 1'b1}},
        '{6'd30, 1'b1, '{OP_MOVEC_WRITE, {1'b0, 3'd4, CTL_VBR}, 16'h2000, 32'h00000000,
            32'h00000000, 1'b1}, 1'b0, '0},
        // CAAR is not readable on the 40 group
        '{6'd40, 1'b1, '{OP_MOVEC_READ, {1'b0, 3'd1, CTL_CAAR}, 16'h2000, 32'h00000000,
            32'h00000000, 1'b1}, 1'b1,
            '{1'b0, 2'd0, 16'h2000, 1'b0, 1'b0, 3'd0, 32'h00000000, 1'b1}},
        // MOVE from SR emulation switched off
        '{6'd40, 1'b0, '{{OP_MOVE_FROM_SR[15:6], EA_DREG, 3'd0}, 16'h0000, 16'h2700,
            32'h00000000, 32'h00000000, 1'b0}, 1'b1,
            '{1'b0, 2'd0, 16'h2700, 1'b0, 1'b0, 3'd0, 32'h00000000, 1'b0}},
        // MOVEC on the oldest generation
        '{6'd0, 1'b0, '{OP_MOVEC_WRITE, {1'b0, 3'd0, CTL_SFC}, 16'h2000, 32'h00000000,
            32'h00000000, 1'b1}, 1'b1,
            '{1'b0, 2'd0, 16'h2000, 1'b0, 1'b0, 3'd0, 32'h00000000, 1'b1}},
        // Odd generation below 10 lists no readable register
        '{6'd5, 1'b1, '{OP_MOVEC_READ, {1'b0, 3'd0, CTL_SFC}, 16'h2000, 32'h00000000,
            32'h00000000, 1'b1}, 1'b1,
            '{1'b0, 2'd0, 16'h2000, 1'b0, 1'b0, 3'd0, 32'h00000000, 1'b1}}
    };

    localparam logic [5:0] PHASE_CPU [PHASE_COUNT] =
        '{6'd0, 6'd10, 6'd20, 6'd30, 6'd40, 6'd60, 6'd5, 6'd50, 6'd60, 6'd25};
    localparam logic PHASE_EMU [PHASE_COUNT] =
        '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

    localparam logic [15:0] KNOWN_OPS [9] = '{OP_MOVE_FROM_SR, OP_ANDI_SR, OP_EORI_SR,
        OP_ORI_SR, OP_RESET, OP_STOP, OP_MOVEC_READ, OP_MOVEC_WRITE, 16'h40c8};

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [ApbAddrWidth-1:0] paddr = '0;
    logic [ApbDataWidth-1:0] pwdata = '0;
    logic [ApbDataWidth-1:0] prdata;
    logic                    pready;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [15:0]             opcode = '0;
    logic [15:0]             ext_word = '0;
    logic [15:0]             status_reg = '0;
    logic [31:0]             reg_value = '0;
    logic [31:0]             usp_value = '0;
    logic                    pretend_super = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    resume;
    logic [1:0]              pc_advance;
    logic [15:0]             new_status;
    logic                    reg_write_en;
    logic                    reg_write_addr;
    logic [2:0]              reg_write_index;
    logic [31:0]             reg_write_value;
    logic                    pretend_super_next;

    // Shadow of the configuration registers
    logic [5:0]  cfg_cpu = CPU_MODEL_RESET;
    logic        cfg_emu = EMULATE_OBSOLETE_RESET;

    pie_result_t verdict_q [$];
    int          verdict_errors = 0;
    int          cfg_errors = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    logic        sink_calm = 1'b0;
    logic        source_calm = 1'b0;

    privileged_instruction_emulator_unit dut (.*);

    always #1 clk = ~clk;

    // Which value a MOVEC read of a control register returns on a given generation
    function automatic pie_movec_kind_t movec_source(input logic [5:0] gen,
                                                     input logic [11:0] ctl);
        pie_movec_kind_t kind;
        kind = MOVEC_NONE;
        if (gen >= CPU_GEN_10) begin
            if (ctl == CTL_SFC || ctl == CTL_DFC || ctl == CTL_VBR)
                kind = MOVEC_ZERO;
            if (ctl == CTL_USP)
                kind = MOVEC_USP;
        end
        if (gen >= CPU_GEN_20) begin
            if (ctl == CTL_CACR)
                kind = MOVEC_ZERO;
            if (ctl == CTL_CAAR && (gen == CPU_GEN_20 || gen == CPU_GEN_30))
                kind = MOVEC_ZERO;
            if (ctl == CTL_MSP || ctl == CTL_ISP)
                kind = MOVEC_USP;
        end
        if (gen >= CPU_GEN_40) begin
            if ((ctl >= CTL_TC && ctl <= CTL_DTT1) || (ctl >= CTL_MMUSR && ctl <= CTL_SRP))
                kind = MOVEC_ZERO;
        end
        return kind;
    endfunction

    // Verdict for one trapped word under the current shadow configuration
    function automatic pie_result_t predict_verdict(input pie_item_t w);
        pie_result_t     r;
        logic [2:0]      ea_mode;
        logic [2:0]      ea_reg;
        pie_movec_kind_t kind;
        // default is a real privilege violation
        r = '0;
        r.new_status = w.status_reg;
        r.pretend_super_next = w.pretend_super;
        ea_mode = w.opcode[5:3];
        ea_reg = w.opcode[2:0];
        if (cfg_emu && (w.opcode & OP_MOVE_SR_MASK) == OP_MOVE_FROM_SR) begin
            r.resume = 1'b1;
            r.pc_advance = 2'd1;
            case (ea_mode)
                EA_DREG:
                begin
                    r.reg_write_en = 1'b1;
                    r.reg_write_index = ea_reg;
                    r.reg_write_value = {w.reg_value[31:16], w.status_reg & SR_MOVE_MASK};
                end
                EA_AIND: ;
                EA_POSTINC, EA_PREDEC:
                begin
                    r.reg_write_en = 1'b1;
                    r.reg_write_addr = 1'b1;
                    r.reg_write_index = ea_reg;
                    r.reg_write_value = (ea_mode == EA_POSTINC) ? w.reg_value + 32'd2
                                                                : w.reg_value - 32'd2;
                end
                EA_DISP: r.pc_advance = 2'd2;
                EA_SPECIAL: r.pc_advance = (ea_reg == 3'd0) ? 2'd2 : 2'd3;
                default:
                begin
                    r.resume = 1'b0;
                    r.pc_advance = 2'd0;
                end
            endcase
            return r;
        end
        if (w.pretend_super) begin
            case (w.opcode)
                OP_ANDI_SR:
                begin
                    r.resume = 1'b1;
                    r.pc_advance = 2'd2;
                    r.new_status = w.status_reg & (w.ext_word | SR_ANDI_KEEP);
                    if (!w.ext_word[13])
                        r.pretend_super_next = 1'b0;
                end
                OP_EORI_SR:
                begin
                    r.resume = 1'b1;
                    r.pc_advance = 2'd2;
                    r.new_status = w.status_reg ^ (w.ext_word & SR_CCR_MASK);
                    if (w.ext_word[13])
                        r.pretend_super_next = 1'b0;
                end
                OP_ORI_SR:
                begin
                    r.resume = 1'b1;
                    r.pc_advance = 2'd2;
                    r.new_status = w.status_reg | (w.ext_word & SR_CCR_MASK);
                end
                OP_RESET:
                begin
                    r.resume = 1'b1;
                    r.pc_advance = 2'd1;
                end
                OP_STOP:
                begin
                    // only a STOP that keeps S set and raises the IPL above 5 faults
                    if (!(w.ext_word[15:13] == 3'b001 && w.ext_word[10:8] > STOP_IPL_LIMIT)) begin
                        r.resume = 1'b1;
                        r.pc_advance = 2'd2;
                    end
                end
                OP_MOVEC_READ:
                begin
                    kind = movec_source(cfg_cpu, w.ext_word[11:0]);
                    if (cfg_cpu != 6'd0 && kind != MOVEC_NONE) begin
                        r.resume = 1'b1;
                        r.pc_advance = 2'd2;
                        r.reg_write_en = 1'b1;
                        r.reg_write_addr = w.ext_word[15];
                        r.reg_write_index = w.ext_word[14:12];
                        r.reg_write_value = (kind == MOVEC_USP) ? w.usp_value : 32'd0;
                    end
                end
                OP_MOVEC_WRITE:
                begin
                    if (cfg_cpu != 6'd0) begin
                        r.resume = 1'b1;
                        r.pc_advance = 2'd2;
                    end
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random trapped word, mostly instructions the block knows with random content
    function automatic pie_item_t random_word();
        pie_item_t  w;
        logic [11:0] ctl;
        int          pick;
        w.opcode = 16'($urandom);
        w.ext_word = 16'($urandom);
        w.status_reg = 16'($urandom);
        w.reg_value = $urandom;
        w.usp_value = $urandom;
        w.pretend_super = ($urandom_range(0, 9) != 0);
        // push the address register updates across the wrap now and then
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0: w.reg_value = 32'h00000000;
                1: w.reg_value = 32'hffffffff;
                2: w.reg_value = 32'h00000001;
                default: w.reg_value = 32'hfffffffe;
            endcase
        end
        ctl = ($urandom_range(0, 1) != 0) ? CTL_USP : CTL_SFC;
        ctl = ctl | 12'($urandom_range(0, 8));
        if ($urandom_range(0, 3) == 0)
            ctl = 12'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 22)
            w.opcode = OP_MOVE_FROM_SR | 16'($urandom_range(0, 63));
        else if (pick < 30)
            w.opcode = OP_ANDI_SR;
        else if (pick < 38)
            w.opcode = OP_EORI_SR;
        else if (pick < 45)
            w.opcode = OP_ORI_SR;
        else if (pick < 50)
            w.opcode = OP_RESET;
        else if (pick < 60) begin
            w.opcode = OP_STOP;
            if ($urandom_range(0, 4) < 3)
                w.ext_word = {3'b001, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                              8'($urandom_range(0, 255))};
        end
        else if (pick < 75) begin
            w.opcode = OP_MOVEC_READ;
            w.ext_word = {1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), ctl};
        end
        else if (pick < 82)
            w.opcode = OP_MOVEC_WRITE;
        else if (pick < 92)
            w.opcode = KNOWN_OPS[$urandom_range(0, 8)] ^ (16'h0001 << $urandom_range(0, 15));
        return w;
    endfunction

    // Offer one word, hold it until taken, and queue its expected verdict
    task automatic drive_word(input pie_item_t w, input logic typed, input pie_result_t fixed);
        in_valid <= 1'b1;
        opcode <= w.opcode;
        ext_word <= w.ext_word;
        status_reg <= w.status_reg;
        reg_value <= w.reg_value;
        usp_value <= w.usp_value;
        pretend_super <= w.pretend_super;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        verdict_q.push_back(typed ? fixed : predict_verdict(w));
    endtask

    task automatic sender_pause(input int cycles);
        if (cycles > 0) begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Drop valid and wait for every outstanding verdict
    task automatic drain();
        if (in_valid)
            in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    // One APB transfer; select is left high so transfers may follow back to back
    task automatic apb_access(input logic wr, input logic [0:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
    endtask

    // Write both registers while idle and read them back
    task automatic set_mode(input logic [5:0] cpu, input logic emu);
        logic [31:0] readback;
        drain();
        apb_access(1'b1, REG_CPU_MODEL, {26'd0, cpu}, readback);
        apb_access(1'b1, REG_EMULATE_OBSOLETE, {31'd0, emu}, readback);
        cfg_cpu = cpu;
        cfg_emu = emu;
        apb_access(1'b0, REG_CPU_MODEL, 32'd0, readback);
        if (readback != {26'd0, cpu}) begin
            $error("cpu_model readback: expected %h, got %h", cpu, readback);
            cfg_errors++;
        end
        apb_access(1'b0, REG_EMULATE_OBSOLETE, 32'd0, readback);
        if (readback != {31'd0, emu}) begin
            $error("emulate_obsolete readback: expected %h, got %h", emu, readback);
            cfg_errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            verdict_errors++;
        end
    endtask

    // Receiver stalls: random runs, no new run started while the sink is calm
    always @(posedge clk) begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (!sink_calm && $urandom_range(0, 3) == 0) begin
            out_stall <= 1'b1;
            stall_left <= idle_len();
        end
        else
            out_stall <= 1'b0;
    end

    // Check every verdict word taken against the oldest expectation
    always @(posedge clk) begin
        pie_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (verdict_q.size() == 0) begin
                $error("verdict word with no expectation waiting");
                verdict_errors++;
            end
            else begin
                want = verdict_q.pop_front();
                compare_field("resume", 32'(want.resume), 32'(resume));
                compare_field("pc_advance", 32'(want.pc_advance), 32'(pc_advance));
                compare_field("new_status", 32'(want.new_status), 32'(new_status));
                compare_field("reg_write_en", 32'(want.reg_write_en), 32'(reg_write_en));
                compare_field("reg_write_addr", 32'(want.reg_write_addr), 32'(reg_write_addr));
                compare_field("reg_write_index", 32'(want.reg_write_index),
                              32'(reg_write_index));
                compare_field("reg_write_value", want.reg_write_value, reg_write_value);
                compare_field("pretend_super_next", 32'(want.pretend_super_next),
                              32'(pretend_super_next));
            end
        end
    end

    // Abandon a run that hangs
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table, switching mode only where a row asks for it
        foreach (TRAP_TABLE[i]) begin
            if (TRAP_TABLE[i].cpu != cfg_cpu || TRAP_TABLE[i].emu != cfg_emu)
                set_mode(TRAP_TABLE[i].cpu, TRAP_TABLE[i].emu);
            drive_word(TRAP_TABLE[i].word, TRAP_TABLE[i].typed, TRAP_TABLE[i].verdict);
            sender_pause(idle_len());
        end

        // Random phases, one configuration each
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            set_mode(PHASE_CPU[phase], PHASE_EMU[phase]);
            sink_calm = (phase % 4 == 1);
            source_calm = (phase % 3 == 2);
            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                drive_word(random_word(), 1'b0, '0);
                if ($urandom_range(0, 199) == 0)
                    drain();
                else
                    sender_pause(source_calm ? 0 : idle_len());
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (verdict_errors == 0 && cfg_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/pie_pkg.sv
rtl/pie_apb_regs.sv
rtl/pie_decode.sv
rtl/privileged_instruction_emulator_unit.sv
tb/privileged_instruction_emulator_unit_test.sv
